// File: hw/rtl/tlc_pkg.sv
// Package for the traffic light controller: phase codes, lamp codes, register indexes,
// request and response payload types, and the fixed phase and lamp tables.
// No dependencies.
`timescale 1ns / 1ps

package tlc_pkg;

    localparam int DWELL_W   = 16;
    localparam int PHASE_W   = 4;
    localparam int LAMP_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int SEL_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR = 2'd3;

    localparam logic [DWELL_W-1:0] DRIVE_DWELL_RST = 16'd200;
    localparam logic [DWELL_W-1:0] FLASH_DWELL_RST = 16'd25;
    localparam logic [DWELL_W-1:0] HOLD_DWELL_RST  = 16'd100;
    localparam logic [DWELL_W-1:0] CLEAR_DWELL_RST = 16'd50;

    localparam logic [PHASE_W-1:0] PH_DRIVE_S = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SLOW_S  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DRIVE_W = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SLOW_W  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WALK    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_FLASH0  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_FLASH1  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_FLASH2  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_FLASH3  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_FLASH4  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_FLASH5  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_FLASH6  = 4'd11;
    localparam logic [PHASE_W-1:0] PH_HOLD    = 4'd12;
    localparam logic [PHASE_W-1:0] PH_HOLD_S  = 4'd13;
    localparam logic [PHASE_W-1:0] PH_HOLD_W  = 4'd14;
    localparam logic [PHASE_W-1:0] PH_HOLD_P  = 4'd15;

    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'd1;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'd2;
    localparam logic [LAMP_W-1:0] LAMP_RED    = 3'd4;
    localparam logic [LAMP_W-1:0] WALK_OFF    = 3'd0;
    localparam logic [LAMP_W-1:0] WALK_RED    = 3'd1;
    localparam logic [LAMP_W-1:0] WALK_WHITE  = 3'd7;

    typedef enum logic [1:0] {
        DW_DRIVE,
        DW_FLASH,
        DW_HOLD,
        DW_CLEAR
    } t_dwell_class;

    typedef struct packed {
        logic west_car;
        logic south_car;
        logic walk_request;
    } t_req;

    typedef struct packed {
        logic [LAMP_W-1:0]  south_lamp;
        logic [LAMP_W-1:0]  west_lamp;
        logic [LAMP_W-1:0]  walk_lamp;
        logic [PHASE_W-1:0] phase_number;
        logic               phase_changed;
    } t_rsp;

    function automatic t_dwell_class dwell_class(input logic [PHASE_W-1:0] phase);
        t_dwell_class cls;
        unique case (phase) inside
            [PH_DRIVE_S:PH_WALK]:   cls = DW_DRIVE;
            [PH_FLASH0:PH_FLASH6]:  cls = DW_FLASH;
            PH_HOLD:                cls = DW_HOLD;
            default:                cls = DW_CLEAR;
        endcase
        return cls;
    endfunction

    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] phase,
                                                      input logic [SEL_W-1:0]   sel);
        logic [PHASE_W-1:0] nxt;
        unique case (phase)
            PH_DRIVE_S: begin
                case (sel) inside
                    3'd0, 3'd2: nxt = PH_DRIVE_S;
                    default:    nxt = PH_SLOW_S;
                endcase
            end
            PH_SLOW_S:  nxt = PH_HOLD_S;
            PH_DRIVE_W: begin
                case (sel) inside
                    3'd0, 3'd4: nxt = PH_DRIVE_W;
                    default:    nxt = PH_SLOW_W;
                endcase
            end
            PH_SLOW_W:  nxt = PH_HOLD_W;
            PH_WALK: begin
                case (sel) inside
                    3'd0, 3'd1: nxt = PH_WALK;
                    default:    nxt = PH_FLASH0;
                endcase
            end
            PH_FLASH0:  nxt = PH_FLASH1;
            PH_FLASH1:  nxt = PH_FLASH2;
            PH_FLASH2:  nxt = PH_FLASH3;
            PH_FLASH3:  nxt = PH_FLASH4;
            PH_FLASH4:  nxt = PH_FLASH5;
            PH_FLASH5:  nxt = PH_FLASH6;
            PH_FLASH6:  nxt = PH_HOLD_P;
            PH_HOLD: begin
                case (sel) inside
                    3'd1:             nxt = PH_WALK;
                    3'd4, 3'd5, 3'd6: nxt = PH_DRIVE_W;
                    default:          nxt = PH_DRIVE_S;
                endcase
            end
            PH_HOLD_S: begin
                case (sel) inside
                    3'd2:       nxt = PH_DRIVE_S;
                    3'd3, 3'd7: nxt = PH_WALK;
                    default:    nxt = PH_HOLD;
                endcase
            end
            PH_HOLD_W: begin
                case (sel) inside
                    3'd5:    nxt = PH_WALK;
                    3'd6:    nxt = PH_DRIVE_S;
                    default: nxt = PH_HOLD;
                endcase
            end
            default: begin
                case (sel) inside
                    3'd7:    nxt = PH_DRIVE_W;
                    default: nxt = PH_HOLD;
                endcase
            end
        endcase
        return nxt;
    endfunction

    function automatic logic [LAMP_W-1:0] south_lamp_of(input logic [PHASE_W-1:0] phase);
        logic [LAMP_W-1:0] lamp;
        case (phase)
            PH_DRIVE_S: lamp = LAMP_GREEN;
            PH_SLOW_S:  lamp = LAMP_YELLOW;
            default:    lamp = LAMP_RED;
        endcase
        return lamp;
    endfunction

    function automatic logic [LAMP_W-1:0] west_lamp_of(input logic [PHASE_W-1:0] phase);
        logic [LAMP_W-1:0] lamp;
        case (phase)
            PH_DRIVE_W: lamp = LAMP_GREEN;
            PH_SLOW_W:  lamp = LAMP_YELLOW;
            default:    lamp = LAMP_RED;
        endcase
        return lamp;
    endfunction

    function automatic logic [LAMP_W-1:0] walk_lamp_of(input logic [PHASE_W-1:0] phase);
        logic [LAMP_W-1:0] lamp;
        case (phase) inside
            PH_WALK:                         lamp = WALK_WHITE;
            PH_FLASH1, PH_FLASH3, PH_FLASH5: lamp = WALK_OFF;
            default:                         lamp = WALK_RED;
        endcase
        return lamp;
    endfunction

endpackage

// File: hw/rtl/tlc_req_if.sv
// Request channel of the traffic light controller: one sensor tick per request.
// Depends on tlc_pkg for the payload type.
`timescale 1ns / 1ps

interface tlc_req_if;
    logic          valid;
    logic          ready;
    tlc_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tlc_rsp_if.sv
// Response channel of the traffic light controller: lamp codes and phase per tick.
// Depends on tlc_pkg for the payload type.
`timescale 1ns / 1ps

interface tlc_rsp_if;
    logic          valid;
    logic          ready;
    tlc_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/traffic_light_controller.sv
// Traffic light controller: Moore phase machine for a two-road crossing with a walk signal.
// Path: a request accepted into the input register passes the phase and dwell update into the
// output register and is presented as a response from there; a stalled output holds it back.
// Throughput: one request per cycle; the input register, phase and dwell update, and the
// output register form a two-stage pipeline that advances whenever the output is free.
// Reset clears both stages, sets drive south, a zero dwell count and default dwell times.
`timescale 1ns / 1ps

module traffic_light_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tlc_req_if.sink                          i_req,
    tlc_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlc_pkg::DWELL_W-1:0]      i_cfg_data
);
    import tlc_pkg::*;

    logic [DWELL_W-1:0] r_drive_dwell;
    logic [DWELL_W-1:0] r_flash_dwell;
    logic [DWELL_W-1:0] r_hold_dwell;
    logic [DWELL_W-1:0] r_clear_dwell;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [DWELL_W-1:0] r_count;
    logic [DWELL_W-1:0] n_count;

    logic               r_in_valid;
    t_req               r_in;
    logic               r_out_valid;
    t_rsp               r_out;
    t_rsp               n_out;

    logic               w_adv;
    logic [SEL_W-1:0]   w_sel;
    logic [DWELL_W-1:0] w_dwell;
    logic [DWELL_W:0]   w_spent;
    logic               w_done;

    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_dwell <= DRIVE_DWELL_RST;
            r_flash_dwell <= FLASH_DWELL_RST;
            r_hold_dwell  <= HOLD_DWELL_RST;
            r_clear_dwell <= CLEAR_DWELL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DRIVE: r_drive_dwell <= i_cfg_data;
                CFG_FLASH: r_flash_dwell <= i_cfg_data;
                CFG_HOLD:  r_hold_dwell  <= i_cfg_data;
                CFG_CLEAR: r_clear_dwell <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_sel = {r_in.west_car, r_in.south_car, r_in.walk_request};
        case (dwell_class(r_phase))
            DW_DRIVE: w_dwell = r_drive_dwell;
            DW_FLASH: w_dwell = r_flash_dwell;
            DW_HOLD:  w_dwell = r_hold_dwell;
            default:  w_dwell = r_clear_dwell;
        endcase
        w_spent = {1'b0, r_count} + {{DWELL_W{1'b0}}, 1'b1};
        w_done  = w_spent >= {1'b0, w_dwell};
        if (w_done) begin
            n_phase = next_phase(r_phase, w_sel);
            n_count = '0;
        end else begin
            n_phase = r_phase;
            n_count = w_spent[DWELL_W-1:0];
        end
        n_out.south_lamp    = south_lamp_of(n_phase);
        n_out.west_lamp     = west_lamp_of(n_phase);
        n_out.walk_lamp     = walk_lamp_of(n_phase);
        n_out.phase_number  = n_phase;
        n_out.phase_changed = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_DRIVE_S;
            r_count     <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    a_hold_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_done) |=> (r_phase == $past(r_phase)))
        else $error("phase moved before its dwell ended");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out.phase_changed == (r_count == '0)))
        else $error("dwell count and phase change flag disagree");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != {DWELL_W{1'b1}})
        else $error("dwell count reached its full range");

    a_no_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.south_lamp == LAMP_GREEN && r_out.west_lamp == LAMP_GREEN))
        else $error("both roads show green");

endmodule

// File: tb/sv/tb_traffic_light_controller.sv
// Self-checking testbench for traffic_light_controller: random sensor ticks and every sensor
// index in turn, with random gaps and response stalls, checked against an in-bench phase and
// dwell predictor. Depends on tlc_pkg, tlc_req_if, tlc_rsp_if and the controller RTL.
`timescale 1ns / 1ps

module tb_traffic_light_controller;
    import tlc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DWELL_W-1:0]   i_cfg_data;

    tlc_req_if req_ch ();
    tlc_rsp_if rsp_ch ();

    traffic_light_controller u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_req        tick_q[$];
    t_rsp        lamp_q[$];
    int unsigned err_cnt = 0;
    int unsigned rsp_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned gap_left;
    int unsigned gap_draw;
    int unsigned stall_left;
    int unsigned stall_draw;
    t_rsp        want;

    logic [PHASE_W-1:0] cur_phase;
    logic [DWELL_W-1:0] dwell_cnt;
    logic [DWELL_W-1:0] dwell_cfg [4];

    function automatic t_dwell_class class_of(input logic [PHASE_W-1:0] ph);
        if (ph <= PH_WALK) return DW_DRIVE;
        if (ph <= PH_FLASH6) return DW_FLASH;
        if (ph == PH_HOLD) return DW_HOLD;
        return DW_CLEAR;
    endfunction

    // Each row holds the successor phase for sensor index 7 down to 0, one nibble each.
    function automatic logic [PHASE_W-1:0] successor(input logic [PHASE_W-1:0] ph,
                                                     input logic [SEL_W-1:0]   sel);
        logic [31:0] row;
        case (ph)
            PH_DRIVE_S: row = 32'h1111_1010;
            PH_SLOW_S:  row = 32'hDDDD_DDDD;
            PH_DRIVE_W: row = 32'h3332_3332;
            PH_SLOW_W:  row = 32'hEEEE_EEEE;
            PH_WALK:    row = 32'h5555_5544;
            PH_FLASH0:  row = 32'h6666_6666;
            PH_FLASH1:  row = 32'h7777_7777;
            PH_FLASH2:  row = 32'h8888_8888;
            PH_FLASH3:  row = 32'h9999_9999;
            PH_FLASH4:  row = 32'hAAAA_AAAA;
            PH_FLASH5:  row = 32'hBBBB_BBBB;
            PH_FLASH6:  row = 32'hFFFF_FFFF;
            PH_HOLD:    row = 32'h0222_0040;
            PH_HOLD_S:  row = 32'h4CCC_40CC;
            PH_HOLD_W:  row = 32'hC04C_CCCC;
            default:    row = 32'h2CCC_CCCC;
        endcase
        return row[sel*4 +: 4];
    endfunction

    function automatic t_rsp advance_phase(input t_req t);
        t_rsp               r;
        logic [SEL_W-1:0]   sel;
        logic [DWELL_W:0]   spent;
        sel = {t.west_car, t.south_car, t.walk_request};
        spent = {1'b0, dwell_cnt} + 1'b1;
        r.phase_changed = (spent >= {1'b0, dwell_cfg[class_of(cur_phase)]});
        if (r.phase_changed) begin
            cur_phase = successor(cur_phase, sel);
            dwell_cnt = '0;
        end else begin
            dwell_cnt = spent[DWELL_W-1:0];
        end
        r.phase_number = cur_phase;
        case (cur_phase)
            PH_DRIVE_S: r.south_lamp = LAMP_GREEN;
            PH_SLOW_S:  r.south_lamp = LAMP_YELLOW;
            default:    r.south_lamp = LAMP_RED;
        endcase
        case (cur_phase)
            PH_DRIVE_W: r.west_lamp = LAMP_GREEN;
            PH_SLOW_W:  r.west_lamp = LAMP_YELLOW;
            default:    r.west_lamp = LAMP_RED;
        endcase
        if (cur_phase == PH_WALK) begin
            r.walk_lamp = WALK_WHITE;
        end else if (cur_phase == PH_FLASH1 || cur_phase == PH_FLASH3
                     || cur_phase == PH_FLASH5) begin
            r.walk_lamp = WALK_OFF;
        end else begin
            r.walk_lamp = WALK_RED;
        end
        return r;
    endfunction

    function automatic int unsigned pick_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [DWELL_W-1:0] pick_dwell();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'hFFFF;
        if (k == 1) return 16'h0000;
        if (k <= 3) return DWELL_W'($urandom_range(6, 40));
        return DWELL_W'($urandom_range(1, 5));
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    // Predictor: tracks register writes and every accepted request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_phase = PH_DRIVE_S;
            dwell_cnt = '0;
            dwell_cfg[DW_DRIVE] = DRIVE_DWELL_RST;
            dwell_cfg[DW_FLASH] = FLASH_DWELL_RST;
            dwell_cfg[DW_HOLD]  = HOLD_DWELL_RST;
            dwell_cfg[DW_CLEAR] = CLEAR_DWELL_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DRIVE: dwell_cfg[DW_DRIVE] = i_cfg_data;
                    CFG_FLASH: dwell_cfg[DW_FLASH] = i_cfg_data;
                    CFG_HOLD:  dwell_cfg[DW_HOLD]  = i_cfg_data;
                    default:   dwell_cfg[DW_CLEAR] = i_cfg_data;
                endcase
            end
            if (req_ch.valid && req_ch.ready) lamp_q.push_back(advance_phase(req_ch.data));
        end
    end

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left <= 0;
        end else if (req_ch.valid && !req_ch.ready) begin
            req_ch.valid <= 1'b1;
        end else if (!req_ch.valid && gap_left != 0) begin
            gap_left <= gap_left - 1;
        end else begin
            gap_draw = req_ch.valid ? pick_wait(sender_calm) : 0;
            if (gap_draw == 0 && tick_q.size() != 0) begin
                req_ch.valid <= 1'b1;
                req_ch.data <= tick_q.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
                gap_left <= gap_draw;
            end
        end
    end

    // Response monitor and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (lamp_q.size() == 0) begin
                note_error($sformatf("cycle %0d: response with no request pending", cycle_cnt));
            end else begin
                want = lamp_q.pop_front();
                if (rsp_ch.data.south_lamp !== want.south_lamp
                    || rsp_ch.data.west_lamp !== want.west_lamp
                    || rsp_ch.data.walk_lamp !== want.walk_lamp
                    || rsp_ch.data.phase_number !== want.phase_number
                    || rsp_ch.data.phase_changed !== want.phase_changed) begin
                    note_error($sformatf(
                        "rsp %0d: exp S%0d W%0d P%0d ph%0d mv%0d got S%0d W%0d P%0d ph%0d mv%0d",
                        rsp_cnt, want.south_lamp, want.west_lamp, want.walk_lamp,
                        want.phase_number, want.phase_changed, rsp_ch.data.south_lamp,
                        rsp_ch.data.west_lamp, rsp_ch.data.walk_lamp,
                        rsp_ch.data.phase_number, rsp_ch.data.phase_changed));
                end
            end
            rsp_cnt++;
            stall_draw = pick_wait(receiver_calm);
            if (stall_draw != 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left <= stall_draw;
            end
        end else if (!rsp_ch.ready) begin
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_random_ticks(input int unsigned n);
        t_req t;
        @(negedge i_clk);
        repeat (n) begin
            t.west_car = 1'($urandom_range(0, 1));
            t.south_car = 1'($urandom_range(0, 1));
            t.walk_request = 1'($urandom_range(0, 1));
            tick_q.push_back(t);
        end
    endtask

    task automatic queue_every_index(input int unsigned rounds);
        int unsigned k;
        @(negedge i_clk);
        for (k = 0; k < rounds * 8; k++) tick_q.push_back(t_req'(k[2:0]));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || req_ch.valid || lamp_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_dwells(input logic [DWELL_W-1:0] drive, input logic [DWELL_W-1:0] flash,
                                input logic [DWELL_W-1:0] hold, input logic [DWELL_W-1:0] clear);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DRIVE;
        i_cfg_data <= drive;
        @(posedge i_clk);
        i_cfg_idx <= CFG_FLASH;
        i_cfg_data <= flash;
        @(posedge i_clk);
        i_cfg_idx <= CFG_HOLD;
        i_cfg_data <= hold;
        @(posedge i_clk);
        i_cfg_idx <= CFG_CLEAR;
        i_cfg_data <= clear;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned round;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DRIVE;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default dwell times, long enough to see the first drive phase end.
        queue_random_ticks(260);
        wait_drained();

        // Every sensor index with the shortest dwell, then with dwells written as zero.
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
        write_dwells(16'd1, 16'd1, 16'd1, 16'd1);
        queue_every_index(2);
        wait_drained();
        write_dwells(16'd0, 16'd0, 16'd0, 16'd0);
        queue_every_index(1);
        wait_drained();

        for (round = 0; round < 10; round++) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            if (round == 0) begin
                write_dwells(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end else begin
                write_dwells(pick_dwell(), pick_dwell(), pick_dwell(), pick_dwell());
            end
            queue_random_ticks(65);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
